// ===== rtl/vsts_pkg.sv =====
// Shared types and constants for the synthesizer tuning serializer.
// No dependencies; used by vsts_frame_build and vtx_synth_tune_serializer.
package vsts_pkg;

   localparam int FRAME_BITS = 25;
   localparam int PAIR_BITS  = 2 * FRAME_BITS;
   localparam int DATA_BITS  = 20;
   localparam int ADDR_BITS  = 4;
   localparam int FREQ_BITS  = 14;
   localparam int TAB_BITS   = 13;
   localparam int BIT_IDX_W  = 6;

   localparam logic [ADDR_BITS-1:0] REF_REG_ADDR   = 4'd0;
   localparam logic [ADDR_BITS-1:0] SYNTH_REG_ADDR = 4'd1;
   localparam logic                 WRITE_FLAG     = 1'b1;

   localparam logic [2:0] BAND_MAX = 3'd4;
   localparam logic [2:0] CHAN_MAX = 3'd7;

   localparam logic [FREQ_BITS-1:0]  FREQ_MIN_RESET = 14'd5600;
   localparam logic [FREQ_BITS-1:0]  FREQ_MAX_RESET = 14'd5950;
   localparam logic [DATA_BITS-1:0]  REF_WORD_RESET = 20'h00190;

   // Bands A B E F R, channel 0..7, in MHz
   localparam logic [TAB_BITS-1:0] CHAN_MHZ [5][8] = '{
      '{13'd5865, 13'd5845, 13'd5825, 13'd5805, 13'd5785, 13'd5765, 13'd5745, 13'd5725},
      '{13'd5733, 13'd5752, 13'd5771, 13'd5790, 13'd5809, 13'd5828, 13'd5847, 13'd5866},
      '{13'd5705, 13'd5685, 13'd5665, 13'd5645, 13'd5885, 13'd5905, 13'd5925, 13'd5945},
      '{13'd5740, 13'd5760, 13'd5780, 13'd5800, 13'd5820, 13'd5840, 13'd5860, 13'd5880},
      '{13'd5658, 13'd5695, 13'd5732, 13'd5769, 13'd5806, 13'd5843, 13'd5880, 13'd5917}
   };

   typedef enum logic [1:0] {
      CSR_FREQ_MIN = 2'd0,
      CSR_FREQ_MAX = 2'd1,
      CSR_REF_WORD = 2'd2
   } csr_index_type;

   typedef struct packed {
      logic [FREQ_BITS-1:0] freq_min;
      logic [FREQ_BITS-1:0] freq_max;
      logic [DATA_BITS-1:0] ref_word;
   } cfg_type;

endpackage

// ===== rtl/vtx_synth_tune_serializer.sv =====
// Top level of the synthesizer tuning serializer: command intake, CSR port,
// serial output register. Depends on vsts_pkg and vsts_frame_build.
//
// A command transaction on req_* (op, freq_mhz, band_sel, channel_sel) is
// turned into two 25-bit write frames, reference register first, then the
// synthesizer register, each LSB first. Every bit leaves as one rsp_*
// transaction with frame_number, frame_end (25th bit of a frame) and last
// (50th bit of the command).
// The first bit passes the pending register and then the output shift
// register before it is valid on rsp_*.
// One bit per cycle leaves the output shift register while rsp_ready is
// high. A pending register holds the next command's frames, so one more
// command can be taken while a command is being shifted out, and the next
// command starts on the cycle after the current last bit is taken.
// When rsp_ready is low the current bit holds. Once the pending register
// is full, req_ready drops until the serializer takes its frames.
// CSRs: freq_min_mhz at 0x0, freq_max_mhz at 0x4, reference_word at 0x8.
// Write them only while idle. Synchronous reset restores the CSR defaults
// and drops all queued work.
module vtx_synth_tune_serializer (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_ready,
   input  logic        req_op,
   input  logic [15:0] req_freq_mhz,
   input  logic [7:0]  req_band_sel,
   input  logic [7:0]  req_channel_sel,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output logic        rsp_serial_bit,
   output logic        rsp_frame_number,
   output logic        rsp_frame_end,
   output logic        rsp_last,
   input  logic        psel,
   input  logic        penable,
   input  logic        pwrite,
   input  logic [3:0]  paddr,
   input  logic [31:0] pwdata,
   output logic [31:0] prdata,
   output logic        pready
);

   localparam logic [vsts_pkg::BIT_IDX_W-1:0] LAST_IDX =
      vsts_pkg::BIT_IDX_W'(vsts_pkg::PAIR_BITS - 1);
   localparam logic [vsts_pkg::BIT_IDX_W-1:0] END0_IDX =
      vsts_pkg::BIT_IDX_W'(vsts_pkg::FRAME_BITS - 1);
   localparam logic [vsts_pkg::BIT_IDX_W-1:0] FRAME1_IDX =
      vsts_pkg::BIT_IDX_W'(vsts_pkg::FRAME_BITS);

   vsts_pkg::cfg_type               cfg_ff, cfg_in;
   vsts_pkg::csr_index_type         csr_idx;
   logic                            csr_wr;

   logic [vsts_pkg::PAIR_BITS-1:0]  frames;
   logic [vsts_pkg::PAIR_BITS-1:0]  pend_frames_ff, pend_frames_in;
   logic                            pend_valid_ff, pend_valid_in;
   logic [vsts_pkg::PAIR_BITS-1:0]  shift_ff, shift_in;
   logic [vsts_pkg::BIT_IDX_W-1:0]  idx_ff, idx_in;
   logic                            out_valid_ff, out_valid_in;

   logic req_take;
   logic rsp_take;
   logic at_last;
   logic load;

   // ---------------- CSR port ----------------
   assign pready  = 1'b1;
   assign csr_idx = vsts_pkg::csr_index_type'(paddr[3:2]);
   assign csr_wr  = psel && penable && pwrite && pready;

   always_comb begin
      cfg_in = cfg_ff;
      prdata = 32'd0;
      unique case (csr_idx)
         vsts_pkg::CSR_FREQ_MIN: begin
            prdata = 32'(cfg_ff.freq_min);
            if (csr_wr) cfg_in.freq_min = pwdata[vsts_pkg::FREQ_BITS-1:0];
         end
         vsts_pkg::CSR_FREQ_MAX: begin
            prdata = 32'(cfg_ff.freq_max);
            if (csr_wr) cfg_in.freq_max = pwdata[vsts_pkg::FREQ_BITS-1:0];
         end
         vsts_pkg::CSR_REF_WORD: begin
            prdata = 32'(cfg_ff.ref_word);
            if (csr_wr) cfg_in.ref_word = pwdata[vsts_pkg::DATA_BITS-1:0];
         end
         default: begin
            prdata = 32'd0;
         end
      endcase
   end

   // ---------------- frame build ----------------
   vsts_frame_build u_build (
      .op          (req_op),
      .freq_mhz    (req_freq_mhz),
      .band_sel    (req_band_sel),
      .channel_sel (req_channel_sel),
      .cfg         (cfg_ff),
      .frames      (frames)
   );

   // ---------------- pending + serializer ----------------
   assign at_last  = (idx_ff == LAST_IDX);
   assign rsp_take = out_valid_ff && rsp_ready;
   assign load     = pend_valid_ff && (!out_valid_ff || (rsp_take && at_last));
   assign req_ready = !pend_valid_ff || load;
   assign req_take  = req_valid && req_ready;

   always_comb begin
      pend_frames_in = pend_frames_ff;
      pend_valid_in  = pend_valid_ff;
      shift_in       = shift_ff;
      idx_in         = idx_ff;
      out_valid_in   = out_valid_ff;

      if (load) begin
         shift_in     = pend_frames_ff;
         idx_in       = '0;
         out_valid_in = 1'b1;
      end else if (rsp_take) begin
         if (at_last) begin
            out_valid_in = 1'b0;
         end else begin
            shift_in = {1'b0, shift_ff[vsts_pkg::PAIR_BITS-1:1]};
            idx_in   = idx_ff + 1'b1;
         end
      end

      if (req_take) begin
         pend_frames_in = frames;
         pend_valid_in  = 1'b1;
      end else if (load) begin
         pend_valid_in  = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.freq_min <= vsts_pkg::FREQ_MIN_RESET;
         cfg_ff.freq_max <= vsts_pkg::FREQ_MAX_RESET;
         cfg_ff.ref_word <= vsts_pkg::REF_WORD_RESET;
         pend_valid_ff   <= 1'b0;
         out_valid_ff    <= 1'b0;
         idx_ff          <= '0;
      end else begin
         cfg_ff          <= cfg_in;
         pend_valid_ff   <= pend_valid_in;
         out_valid_ff    <= out_valid_in;
         idx_ff          <= idx_in;
      end
   end

   always_ff @(posedge clock) begin
      pend_frames_ff <= pend_frames_in;
      shift_ff       <= shift_in;
   end

   assign rsp_valid        = out_valid_ff;
   assign rsp_serial_bit   = shift_ff[0];
   assign rsp_frame_number = (idx_ff >= FRAME1_IDX);
   assign rsp_frame_end    = (idx_ff == END0_IDX) || at_last;
   assign rsp_last         = at_last;

   // ---------------- assertions ----------------
   a_last_ends_frame1: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_last |-> rsp_frame_end && rsp_frame_number)
      else $error("last bit not on end of synthesizer frame");

   a_no_gap_in_command: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_ready && !rsp_last |=> rsp_valid)
      else $error("bit stream broke inside a command");

   a_frame_switch: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_ready && rsp_frame_end && !rsp_last |=> rsp_frame_number)
      else $error("second frame did not follow first frame end");

   a_stall_only_when_full: assert property (@(posedge clock) disable iff (reset)
      !req_ready |-> pend_valid_ff && out_valid_ff)
      else $error("command intake stalled with room available");

endmodule

// ===== rtl/vsts_frame_build.sv =====
// Builds the two 25-bit write frames for one tuning command.
// Depends on vsts_pkg (frame layout, channel table, config struct).
module vsts_frame_build (
   input  logic                           op,
   input  logic [15:0]                    freq_mhz,
   input  logic [7:0]                     band_sel,
   input  logic [7:0]                     channel_sel,
   input  vsts_pkg::cfg_type              cfg,
   output logic [vsts_pkg::PAIR_BITS-1:0] frames
);

   logic [15:0]                    f_lo;
   logic [vsts_pkg::FREQ_BITS-1:0] f_direct;
   logic [2:0]                     band;
   logic [2:0]                     chan;
   logic [vsts_pkg::FREQ_BITS-1:0] f_sel;
   logic [18:0]                    v;
   logic [vsts_pkg::DATA_BITS-1:0] word;

   always_comb begin
      // raise to min first, then lower to max
      f_lo = (freq_mhz < {2'b00, cfg.freq_min}) ? {2'b00, cfg.freq_min} : freq_mhz;
      f_direct = (f_lo > {2'b00, cfg.freq_max}) ? cfg.freq_max
                                                : f_lo[vsts_pkg::FREQ_BITS-1:0];
      band = (band_sel > {5'd0, vsts_pkg::BAND_MAX}) ? vsts_pkg::BAND_MAX : band_sel[2:0];
      chan = (channel_sel > {5'd0, vsts_pkg::CHAN_MAX}) ? vsts_pkg::CHAN_MAX
                                                        : channel_sel[2:0];
      f_sel = op ? {1'b0, vsts_pkg::CHAN_MHZ[band][chan]} : f_direct;
      v = 19'(f_sel) * 19'd25;
      word = {v[18:6], 1'b0, v[5:0]};
      frames = {word, vsts_pkg::WRITE_FLAG, vsts_pkg::SYNTH_REG_ADDR,
                cfg.ref_word, vsts_pkg::WRITE_FLAG, vsts_pkg::REF_REG_ADDR};
   end

endmodule
